>>> src/prqs_pkg.sv
`timescale 1ns / 1ps

package prqs_pkg;

  localparam int unsigned NumTasks  = 64;
  localparam int unsigned NumLevels = 32;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_STARTUP = 3'd1,
    CMD_YIELD   = 3'd2,
    CMD_SLEEP   = 3'd3,
    CMD_WAKEUP  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    TS_FREE     = 2'd0,
    TS_READY    = 2'd1,
    TS_RUNNING  = 2'd2,
    TS_SLEEPING = 2'd3
  } task_state_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_NONE    = 2'd1,
    RES_IGNORED = 2'd2
  } res_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_LEVEL,
    OP_SET_SLEEP,
    OP_SET_READY,
    OP_RD_TGT,
    OP_RD_Q,
    OP_UNLINK_WR,
    OP_ENQ_WR,
    OP_PICK_RD,
    OP_PICK_LATCH,
    OP_RUN_TID,
    OP_SWITCH,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [1:0] {
    SEL_TID,
    SEL_CUR,
    SEL_PICK
  } sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UN_RD,
    ST_UN_Q,
    ST_UN_WR,
    ST_EN_RD,
    ST_EN_Q,
    ST_EN_WR,
    ST_PK_RD,
    ST_PK_LATCH,
    ST_PK_DEC,
    ST_SWITCH,
    ST_RUN,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] task_id;
    logic [4:0] priority_req;
  } req_t;

  typedef struct packed {
    logic       switched;
    logic [5:0] from_task;
    logic [5:0] to_task;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    dp_op_e op;
    sel_e   sel;
    res_e   res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        id_ok;
    logic        started;
    task_state_e tid_state;
    logic        any_ready;
    logic        cur_running;
    logic        keep;
    logic        out_free;
  } dp_stat_t;

endpackage

>>> src/prqs_ctrl.sv
`timescale 1ns / 1ps

module prqs_ctrl import prqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        sched_q, sched_d;
  res_e        res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sched_q <= 1'b0;
      res_q   <= RES_OK;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
      res_q   <= res_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    sched_d   = sched_q;
    res_d     = res_q;
    cmd_o.op  = OP_NONE;
    cmd_o.sel = SEL_TID;
    cmd_o.res = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (cmd_e'(stat_i.command))
          CMD_START: begin
            if (stat_i.started || !stat_i.id_ok || stat_i.tid_state != TS_READY) begin
              res_d   = RES_IGNORED;
              state_d = ST_FIN;
            end else begin
              res_d   = RES_OK;
              state_d = ST_UN_RD;
            end
          end
          CMD_STARTUP: begin
            if (!stat_i.id_ok || stat_i.tid_state != TS_FREE) begin
              res_d   = RES_IGNORED;
              state_d = ST_FIN;
            end else begin
              cmd_o.op = OP_SET_LEVEL;
              res_d    = RES_OK;
              state_d  = ST_EN_RD;
            end
          end
          CMD_YIELD, CMD_SLEEP: begin
            if (!stat_i.started || !stat_i.any_ready) begin
              res_d   = RES_NONE;
              state_d = ST_FIN;
            end else begin
              if (cmd_e'(stat_i.command) == CMD_SLEEP) begin
                cmd_o.op = OP_SET_SLEEP;
              end
              res_d   = RES_OK;
              sched_d = 1'b1;
              state_d = ST_PK_RD;
            end
          end
          CMD_WAKEUP: begin
            if (!stat_i.started) begin
              res_d   = RES_NONE;
              state_d = ST_FIN;
            end else if (!stat_i.id_ok || stat_i.tid_state != TS_SLEEPING) begin
              res_d   = RES_IGNORED;
              state_d = ST_FIN;
            end else begin
              cmd_o.op = OP_SET_READY;
              res_d    = RES_OK;
              state_d  = ST_EN_RD;
            end
          end
          default: begin
            res_d   = RES_IGNORED;
            state_d = ST_FIN;
          end
        endcase
      end
      ST_UN_RD: begin
        cmd_o.op  = OP_RD_TGT;
        cmd_o.sel = sched_q ? SEL_PICK : SEL_TID;
        state_d   = ST_UN_Q;
      end
      ST_UN_Q: begin
        cmd_o.op = OP_RD_Q;
        state_d  = ST_UN_WR;
      end
      ST_UN_WR: begin
        cmd_o.op = OP_UNLINK_WR;
        if (!sched_q) begin
          state_d = ST_RUN;
        end else if (stat_i.cur_running) begin
          state_d = ST_EN_RD;
        end else begin
          state_d = ST_SWITCH;
        end
      end
      ST_EN_RD: begin
        cmd_o.op  = OP_RD_TGT;
        cmd_o.sel = sched_q ? SEL_CUR : SEL_TID;
        state_d   = ST_EN_Q;
      end
      ST_EN_Q: begin
        cmd_o.op = OP_RD_Q;
        state_d  = ST_EN_WR;
      end
      ST_EN_WR: begin
        cmd_o.op = OP_ENQ_WR;
        if (sched_q) begin
          state_d = ST_SWITCH;
        end else if (cmd_e'(stat_i.command) == CMD_WAKEUP) begin
          sched_d = 1'b1;
          state_d = ST_PK_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_PK_RD: begin
        cmd_o.op = OP_PICK_RD;
        state_d  = ST_PK_LATCH;
      end
      ST_PK_LATCH: begin
        cmd_o.op = OP_PICK_LATCH;
        state_d  = ST_PK_DEC;
      end
      ST_PK_DEC: begin
        state_d = stat_i.keep ? ST_FIN : ST_UN_RD;
      end
      ST_SWITCH: begin
        cmd_o.op = OP_SWITCH;
        state_d  = ST_FIN;
      end
      ST_RUN: begin
        cmd_o.op = OP_RUN_TID;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.op = OP_FINISH;
        if (stat_i.out_free) begin
          sched_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/prqs_dp.sv
`timescale 1ns / 1ps

module prqs_dp import prqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      in_req_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output rsp_t      out_req_o
);

  localparam int unsigned TW = $clog2(NumTasks);
  localparam int unsigned LW = $clog2(NumLevels);

  req_t             req_q;
  logic [TW-1:0]    old_q, run_q, tgt_q, pick_q;
  logic             started_q, cur_run_q;
  logic [LW-1:0]    lv_q, plv_q, curlv_q;
  logic [NumLevels-1:0] ne_q;
  logic [NumTasks-1:0]  ts_vld_q;
  logic             out_valid_q;
  rsp_t             out_q;

  task_state_e   tstate_mem [NumTasks];
  logic [LW-1:0] lvl_mem [NumTasks];
  logic [TW-1:0] nxt_mem [NumTasks];
  logic [TW-1:0] prv_mem [NumTasks];
  logic [TW-1:0] head_mem [NumLevels];
  logic [TW-1:0] tail_mem [NumLevels];

  logic [LW-1:0] lvl_rd;
  logic [TW-1:0] nxt_rd, prv_rd, head_rd, tail_rd;
  task_state_e   ts_rd;
  logic          ts_rd_vld;

  logic [TW-1:0] tid_idx, ld_idx, tgt_addr, lvl_ra;
  logic [LW-1:0] q_ra, enc, sat_lv;
  logic          id_ok, any_ready, cur_running, keep, out_free, fin_load;
  logic          is_h, is_t, q_ne;

  logic          nxt_we, prv_we, head_we, tail_we, ne_set, ne_clr;
  logic [TW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, head_wd, tail_wd;
  logic          ts_we;
  logic [TW-1:0] ts_wa;
  task_state_e   ts_wd;

  assign tid_idx     = TW'(req_q.task_id);
  assign ld_idx      = TW'(in_req_i.task_id);
  assign id_ok       = 32'(req_q.task_id) < NumTasks;
  assign sat_lv      = (32'(req_q.priority_req) < NumLevels) ? LW'(req_q.priority_req)
                                                             : LW'(NumLevels - 1);
  assign any_ready   = |ne_q;
  assign cur_running = cur_run_q;
  assign keep        = (cur_running && (plv_q > curlv_q)) || (pick_q == run_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_load    = (cmd_i.op == OP_FINISH) && out_free;

  always_comb begin
    enc = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (ne_q[i]) begin
        enc = LW'(i);
      end
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_CUR:  tgt_addr = run_q;
      SEL_PICK: tgt_addr = pick_q;
      default:  tgt_addr = tid_idx;
    endcase
  end

  assign lvl_ra = (cmd_i.op == OP_PICK_RD) ? run_q : tgt_addr;
  assign q_ra   = (cmd_i.op == OP_PICK_RD) ? enc : lvl_rd;

  assign q_ne = ne_q[lv_q];
  assign is_h = (head_rd == tgt_q);
  assign is_t = (tail_rd == tgt_q);

  // A task that is enqueued becomes ready in the write step of the enqueue.
  always_comb begin
    ts_we = 1'b1;
    ts_wa = tid_idx;
    ts_wd = TS_READY;
    case (cmd_i.op)
      OP_SET_LEVEL, OP_SET_READY: begin
      end
      OP_SET_SLEEP: begin
        ts_wa = run_q;
        ts_wd = TS_SLEEPING;
      end
      OP_RUN_TID: begin
        ts_wd = TS_RUNNING;
      end
      OP_ENQ_WR: begin
        ts_wa = tgt_q;
      end
      OP_SWITCH: begin
        ts_wa = pick_q;
        ts_wd = TS_RUNNING;
      end
      default: begin
        ts_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt_we  = 1'b0;
    nxt_wa  = tgt_q;
    nxt_wd  = tgt_q;
    prv_we  = 1'b0;
    prv_wa  = tgt_q;
    prv_wd  = tail_rd;
    head_we = 1'b0;
    head_wd = tgt_q;
    tail_we = 1'b0;
    tail_wd = tgt_q;
    ne_set  = 1'b0;
    ne_clr  = 1'b0;
    case (cmd_i.op)
      OP_UNLINK_WR: begin
        if (q_ne) begin
          if (is_h && is_t) begin
            ne_clr = 1'b1;
          end else begin
            if (is_h) begin
              head_we = 1'b1;
              head_wd = nxt_rd;
            end else begin
              nxt_we = 1'b1;
              nxt_wa = prv_rd;
              nxt_wd = nxt_rd;
            end
            if (is_t) begin
              tail_we = 1'b1;
              tail_wd = prv_rd;
            end else begin
              prv_we = 1'b1;
              prv_wa = nxt_rd;
              prv_wd = prv_rd;
            end
          end
        end
      end
      OP_ENQ_WR: begin
        tail_we = 1'b1;
        if (q_ne) begin
          nxt_we = 1'b1;
          nxt_wa = tail_rd;
          prv_we = 1'b1;
        end else begin
          head_we = 1'b1;
          ne_set  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ts_we) begin
      tstate_mem[ts_wa] <= ts_wd;
    end
    if (cmd_i.op == OP_LOAD) begin
      ts_rd     <= tstate_mem[ld_idx];
      ts_rd_vld <= ts_vld_q[ld_idx];
    end
    if (cmd_i.op == OP_SET_LEVEL) begin
      lvl_mem[tid_idx] <= sat_lv;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (head_we) begin
      head_mem[lv_q] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[lv_q] <= tail_wd;
    end
    if (cmd_i.op == OP_RD_TGT || cmd_i.op == OP_PICK_RD) begin
      lvl_rd <= lvl_mem[lvl_ra];
      nxt_rd <= nxt_mem[tgt_addr];
      prv_rd <= prv_mem[tgt_addr];
    end
    if (cmd_i.op == OP_RD_Q || cmd_i.op == OP_PICK_RD) begin
      head_rd <= head_mem[q_ra];
      tail_rd <= tail_mem[q_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      req_q <= in_req_i;
      old_q <= run_q;
    end
    if (cmd_i.op == OP_RD_TGT) begin
      tgt_q <= tgt_addr;
    end
    if (cmd_i.op == OP_RD_Q) begin
      lv_q <= lvl_rd;
    end
    if (cmd_i.op == OP_PICK_RD) begin
      plv_q <= enc;
    end
    if (cmd_i.op == OP_PICK_LATCH) begin
      pick_q  <= head_rd;
      curlv_q <= lvl_rd;
    end
    if (fin_load) begin
      out_q.switched  <= (run_q != old_q) ||
                         ((cmd_e'(req_q.command) == CMD_START) && (cmd_i.res == RES_OK));
      out_q.from_task <= 6'(old_q);
      out_q.to_task   <= 6'(run_q);
      out_q.status    <= cmd_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      started_q   <= 1'b0;
      cur_run_q   <= 1'b0;
      ne_q        <= '0;
      ts_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ne_set) begin
        ne_q[lv_q] <= 1'b1;
      end
      if (ne_clr) begin
        ne_q[lv_q] <= 1'b0;
      end
      if (ts_we) begin
        ts_vld_q[ts_wa] <= 1'b1;
      end
      case (cmd_i.op)
        OP_SET_SLEEP: cur_run_q <= 1'b0;
        OP_RUN_TID: begin
          run_q     <= tid_idx;
          started_q <= 1'b1;
          cur_run_q <= 1'b1;
        end
        OP_SWITCH: begin
          run_q     <= pick_q;
          cur_run_q <= 1'b1;
        end
        default: begin
        end
      endcase
      out_valid_q <= fin_load || (out_valid_q && out_stall_i);
    end
  end

  assign stat_o.command     = req_q.command;
  assign stat_o.id_ok       = id_ok;
  assign stat_o.started     = started_q;
  assign stat_o.tid_state   = ts_rd_vld ? ts_rd : TS_FREE;
  assign stat_o.any_ready   = any_ready;
  assign stat_o.cur_running = cur_running;
  assign stat_o.keep        = keep;
  assign stat_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("Scheduler left the started state.");

  a_run_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RUN_TID) |-> !started_q)
    else $error("Start was executed twice.");

  a_unlink_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_UNLINK_WR) |-> ne_q[lv_q])
    else $error("Unlink from an empty ready queue.");

  a_switch_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SWITCH) |-> (pick_q != run_q))
    else $error("Switch to the task that is already running.");

endmodule

>>> src/priority_ready_queue_scheduler_core.sv
`timescale 1ns / 1ps

// Fixed-priority round-robin task scheduler with one FIFO ready queue per level, level 0
// highest. One request is handled at a time and gives one response. After load and decode,
// an ignored or refused request finishes at once, a start unlinks and runs its task, a
// startup or wakeup enqueues its task, and a yield, sleep or wakeup picks the next task and
// keeps or switches. The sequencer walks the link, level and queue memories through one
// registered read and one write step at a time. A new request is taken once the previous
// response has been placed in the output register.
module priority_ready_queue_scheduler_core import prqs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_req_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  prqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prqs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

endmodule
